>>> hw/rtl/rau_pkg.sv
// Shared types and constants for the rational arithmetic unit.
`default_nettype none
package rau_pkg;
   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;
   localparam logic [1:0] OP_DIV = 2'd3;
   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_ZERO_DEN = 2'd1;
   localparam logic [1:0] ST_DIV_ZERO = 2'd2;
   localparam int NUM_BITS = 33;
   localparam int DEN_BITS = 32;
   typedef logic [1:0] op_type;
endpackage
`default_nettype wire

>>> hw/rtl/rau_front.sv
// Front part: forms signed products and magnitudes of one item, with error checks.
`default_nettype none
module rau_front #(
   parameter int OPERAND_BITS = 16,
   parameter int MAG_BITS = 2 * OPERAND_BITS + 1
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic in_valid,
   output logic in_stall,
   input wire rau_pkg::op_type op,
   input wire logic signed [OPERAND_BITS-1:0] num_a,
   input wire logic signed [OPERAND_BITS-1:0] den_a,
   input wire logic signed [OPERAND_BITS-1:0] num_b,
   input wire logic signed [OPERAND_BITS-1:0] den_b,
   output logic out_valid,
   input wire logic out_stall,
   output logic out_nneg,
   output logic out_dneg,
   output logic [MAG_BITS-1:0] out_nmag,
   output logic [MAG_BITS-1:0] out_dmag,
   output logic [1:0] out_status
);
   import rau_pkg::*;
   localparam int OB = OPERAND_BITS;
   localparam int PB = 2 * OPERAND_BITS;

   // Stage 1 holds the products, signs and status; stage 2 holds the combined result.
   logic s1_valid_ff, s1_valid_in, s2_valid_ff, s2_valid_in;
   logic [1:0] s1_op_ff, s1_status_ff, s1_status_in;
   logic s1_sa_ff, s1_sb_ff, s1_dn_ff, s1_n_ff;
   logic [PB-1:0] s1_ma_ff, s1_mb_ff, s1_md_ff;
   logic s1_sa_in, s1_sb_in, s1_dn_in;
   logic [PB-1:0] s1_ma_in, s1_mb_in, s1_md_in;
   logic nneg_ff, nneg_in, dneg_ff;
   logic [MAG_BITS-1:0] nmag_ff, nmag_in, dmag_ff;
   logic [1:0] status_ff;
   logic [OB-1:0] ana, ada, anb, adb, x2, y2;
   logic sx2, sy2, s1_adv, s2_adv;

   function automatic logic [OB-1:0] mag(input logic [OB-1:0] v);
      return v[OB-1] ? (~v + 1'b1) : v;
   endfunction

   assign ana = mag(num_a);
   assign ada = mag(den_a);
   assign anb = mag(num_b);
   assign adb = mag(den_b);
   assign s2_adv = !s2_valid_ff || !out_stall;
   assign s1_adv = !s1_valid_ff || s2_adv;
   assign in_stall = !s1_adv;

   always_comb begin
      s1_status_in = ST_OK;
      if (den_a == '0 || den_b == '0) begin
         s1_status_in = ST_ZERO_DEN;
      end else if (op == OP_DIV && num_b == '0) begin
         s1_status_in = ST_DIV_ZERO;
      end
      x2 = (op == OP_DIV) ? adb : anb;
      y2 = (op == OP_DIV) ? anb : adb;
      sx2 = (op == OP_DIV) ? den_b[OB-1] : num_b[OB-1];
      sy2 = (op == OP_DIV) ? num_b[OB-1] : den_b[OB-1];
      if (op == OP_ADD || op == OP_SUB) begin
         s1_ma_in = PB'(ana) * PB'(adb);
         s1_mb_in = PB'(anb) * PB'(ada);
         s1_sa_in = num_a[OB-1] ^ den_b[OB-1];
         s1_sb_in = num_b[OB-1] ^ den_a[OB-1];
      end else begin
         s1_ma_in = PB'(ana) * PB'(x2);
         s1_mb_in = '0;
         s1_sa_in = num_a[OB-1] ^ sx2;
         s1_sb_in = 1'b0;
      end
      s1_md_in = (op == OP_ADD || op == OP_SUB) ? PB'(ada) * PB'(adb) : PB'(ada) * PB'(y2);
      s1_dn_in = (op == OP_ADD || op == OP_SUB) ? (den_a[OB-1] ^ den_b[OB-1])
                                                : (den_a[OB-1] ^ sy2);
      s1_valid_in = s1_adv ? in_valid : s1_valid_ff;
   end

   always_comb begin
      logic sb;
      logic [MAG_BITS-1:0] a, b;
      a = MAG_BITS'(s1_ma_ff);
      b = MAG_BITS'(s1_mb_ff);
      sb = s1_sb_ff;
      if (s1_op_ff == OP_SUB && b != '0) begin
         sb = !sb;
      end
      if (s1_sa_ff == sb) begin
         nneg_in = s1_sa_ff;
         nmag_in = a + b;
      end else if (a >= b) begin
         nneg_in = s1_sa_ff;
         nmag_in = a - b;
      end else begin
         nneg_in = sb;
         nmag_in = b - a;
      end
      if (nmag_in == '0) begin
         nneg_in = 1'b0;
      end
      s2_valid_in = s2_adv ? s1_valid_ff : s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      if (s1_adv) begin
         s1_op_ff <= op;
         s1_status_ff <= s1_status_in;
         s1_ma_ff <= s1_ma_in;
         s1_mb_ff <= s1_mb_in;
         s1_md_ff <= s1_md_in;
         s1_sa_ff <= s1_sa_in;
         s1_sb_ff <= s1_sb_in;
         s1_dn_ff <= s1_dn_in;
         s1_n_ff <= 1'b0;
      end
      if (s2_adv) begin
         nneg_ff <= nneg_in;
         nmag_ff <= nmag_in;
         dneg_ff <= s1_dn_ff | s1_n_ff;
         dmag_ff <= MAG_BITS'(s1_md_ff);
         status_ff <= s1_status_ff;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_nneg = nneg_ff;
   assign out_dneg = dneg_ff;
   assign out_nmag = nmag_ff;
   assign out_dmag = dmag_ff;
   assign out_status = status_ff;
endmodule
`default_nettype wire

>>> hw/rtl/rau_queue.sv
// Two-entry queue between the front and back parts.
`default_nettype none
module rau_queue #(
   parameter int WIDTH = 8
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic in_valid,
   output logic in_stall,
   input wire logic [WIDTH-1:0] in_data,
   output logic out_valid,
   input wire logic out_stall,
   output logic [WIDTH-1:0] out_data
);
   logic [WIDTH-1:0] mem_ff [2];
   logic wptr_ff, rptr_ff;
   logic [1:0] count_ff;
   logic push, pop;

   assign in_stall = count_ff == 2'd2;
   assign out_valid = count_ff != 2'd0;
   assign out_data = mem_ff[rptr_ff];
   assign push = in_valid && !in_stall;
   assign pop = out_valid && !out_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) wptr_ff <= !wptr_ff;
         if (pop) rptr_ff <= !rptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
      if (push) mem_ff[wptr_ff] <= in_data;
   end
endmodule
`default_nettype wire

>>> hw/rtl/rau_back.sv
// Back part: binary GCD of the magnitudes, then two bit-serial divisions.
`default_nettype none
module rau_back #(
   parameter int MAG_BITS = 33
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic in_valid,
   output logic in_stall,
   input wire logic in_nneg,
   input wire logic in_dneg,
   input wire logic [MAG_BITS-1:0] in_nmag,
   input wire logic [MAG_BITS-1:0] in_dmag,
   input wire logic [1:0] in_status,
   output logic out_valid,
   input wire logic out_stall,
   output logic signed [rau_pkg::NUM_BITS-1:0] out_num,
   output logic signed [rau_pkg::DEN_BITS-1:0] out_den,
   output logic [1:0] out_status
);
   import rau_pkg::*;
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_GCD = 3'd1;
   localparam logic [2:0] S_DIVN = 3'd2;
   localparam logic [2:0] S_DIVD = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;
   localparam int CB = $clog2(MAG_BITS + 1);

   logic [2:0] state_ff;
   logic [MAG_BITS-1:0] nmag_ff, dmag_ff, u_ff, v_ff, q_ff, r_ff, g_ff, src_ff;
   logic [CB-1:0] shift_ff, cnt_ff;
   logic nneg_ff, dneg_ff;
   logic [1:0] status_ff;
   logic [NUM_BITS-1:0] num_ff;
   logic [DEN_BITS-1:0] den_ff;
   logic [MAG_BITS:0] rtry;
   logic [MAG_BITS-1:0] gfull;

   assign in_stall = state_ff != S_IDLE;
   assign out_valid = state_ff == S_DONE;
   assign out_num = num_ff;
   assign out_den = den_ff;
   assign out_status = status_ff;
   assign rtry = {r_ff, src_ff[MAG_BITS-1]} - {1'b0, g_ff};
   assign gfull = u_ff << shift_ff;

   function automatic logic [DEN_BITS-1:0] enc_d(input logic n, input logic [MAG_BITS-1:0] m);
      logic [DEN_BITS-1:0] t;
      t = DEN_BITS'(m);
      return n ? (~t + 1'b1) : t;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (in_valid) begin
                  nneg_ff <= in_nneg;
                  dneg_ff <= in_dneg;
                  nmag_ff <= in_nmag;
                  dmag_ff <= in_dmag;
                  status_ff <= in_status;
                  u_ff <= in_nmag;
                  v_ff <= in_dmag;
                  shift_ff <= '0;
                  if (in_status != ST_OK) begin
                     num_ff <= '0;
                     den_ff <= '0;
                     state_ff <= S_DONE;
                  end else if (in_nmag == '0) begin
                     num_ff <= '0;
                     den_ff <= in_dneg ? '1 : DEN_BITS'(1);
                     state_ff <= S_DONE;
                  end else begin
                     state_ff <= S_GCD;
                  end
               end
            end
            S_GCD: begin
               if (u_ff == v_ff) begin
                  g_ff <= gfull;
                  src_ff <= nmag_ff;
                  r_ff <= '0;
                  q_ff <= '0;
                  cnt_ff <= CB'(MAG_BITS);
                  state_ff <= S_DIVN;
               end else if (!u_ff[0] && !v_ff[0]) begin
                  u_ff <= u_ff >> 1;
                  v_ff <= v_ff >> 1;
                  shift_ff <= shift_ff + 1'b1;
               end else if (!u_ff[0]) begin
                  u_ff <= u_ff >> 1;
               end else if (!v_ff[0]) begin
                  v_ff <= v_ff >> 1;
               end else if (u_ff > v_ff) begin
                  u_ff <= (u_ff - v_ff) >> 1;
               end else begin
                  v_ff <= (v_ff - u_ff) >> 1;
               end
            end
            S_DIVN, S_DIVD: begin
               if (!rtry[MAG_BITS]) begin
                  r_ff <= rtry[MAG_BITS-1:0];
                  q_ff <= {q_ff[MAG_BITS-2:0], 1'b1};
               end else begin
                  r_ff <= {r_ff[MAG_BITS-2:0], src_ff[MAG_BITS-1]};
                  q_ff <= {q_ff[MAG_BITS-2:0], 1'b0};
               end
               src_ff <= src_ff << 1;
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == CB'(1)) begin
                  if (state_ff == S_DIVN) begin
                     num_ff <= nneg_ff ? ~NUM_BITS'({q_ff[MAG_BITS-2:0], !rtry[MAG_BITS]}) + 1'b1
                                       : NUM_BITS'({q_ff[MAG_BITS-2:0], !rtry[MAG_BITS]});
                     src_ff <= dmag_ff;
                     r_ff <= '0;
                     q_ff <= '0;
                     cnt_ff <= CB'(MAG_BITS);
                     state_ff <= S_DIVD;
                  end else begin
                     den_ff <= enc_d(dneg_ff, {q_ff[MAG_BITS-2:0], !rtry[MAG_BITS]});
                     state_ff <= S_DONE;
                  end
               end
            end
            S_DONE: begin
               if (!out_stall) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

>>> hw/rtl/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit.
// Each item passes the front stages and the queue; the back part then runs binary GCD
// reduction steps on the magnitudes and divides both magnitudes by the GCD bit-serially.
// The back part takes a new item only after its last result has been taken.
// Errors and zero numerators skip the GCD and divisions. Reset is synchronous and clears control.
`default_nettype none
module rational_arithmetic_unit #(
   parameter int OPERAND_BITS = 16
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_stall,
   input wire logic [1:0] req_type,
   input wire logic signed [OPERAND_BITS-1:0] req_num_a,
   input wire logic signed [OPERAND_BITS-1:0] req_den_a,
   input wire logic signed [OPERAND_BITS-1:0] req_num_b,
   input wire logic signed [OPERAND_BITS-1:0] req_den_b,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output logic signed [rau_pkg::NUM_BITS-1:0] rsp_result_num,
   output logic signed [rau_pkg::DEN_BITS-1:0] rsp_result_den,
   output logic [1:0] rsp_status
);
   import rau_pkg::*;
   localparam int MB = 2 * OPERAND_BITS + 1;
   localparam int QW = 2 * MB + 4;

   logic f_valid, f_stall, f_nneg, f_dneg, b_valid, b_stall;
   logic [MB-1:0] f_nmag, f_dmag;
   logic [1:0] f_status;
   logic [QW-1:0] b_data;

   rau_front #(.OPERAND_BITS(OPERAND_BITS), .MAG_BITS(MB)) u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_stall(req_stall), .op(req_type),
      .num_a(req_num_a), .den_a(req_den_a), .num_b(req_num_b), .den_b(req_den_b),
      .out_valid(f_valid), .out_stall(f_stall), .out_nneg(f_nneg), .out_dneg(f_dneg),
      .out_nmag(f_nmag), .out_dmag(f_dmag), .out_status(f_status)
   );

   rau_queue #(.WIDTH(QW)) u_queue (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_stall(f_stall),
      .in_data({f_nneg, f_dneg, f_nmag, f_dmag, f_status}),
      .out_valid(b_valid), .out_stall(b_stall), .out_data(b_data)
   );

   rau_back #(.MAG_BITS(MB)) u_back (
      .clock(clock), .reset(reset),
      .in_valid(b_valid), .in_stall(b_stall),
      .in_nneg(b_data[QW-1]), .in_dneg(b_data[QW-2]),
      .in_nmag(b_data[QW-3 -: MB]), .in_dmag(b_data[MB+1:2]), .in_status(b_data[1:0]),
      .out_valid(rsp_valid), .out_stall(rsp_stall),
      .out_num(rsp_result_num), .out_den(rsp_result_den), .out_status(rsp_status)
   );
endmodule
`default_nettype wire
